// File: rtl/spq_pkg.sv
package spq_pkg;

   localparam int DEPTH_DEFAULT        = 16;
   localparam int KEY_BITS_DEFAULT     = 32;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_RANGE   = 2'd2
   } action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] item_key;
      logic [31:0] item_payload;
      logic [31:0] range_low;
      logic [31:0] range_high;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] out_key;
      logic [31:0] out_payload;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/spq_store.sv
module spq_store
   import spq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int KEY_BITS     = KEY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT,
   localparam int AW          = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic [KEY_BITS-1:0]     rd_key_ff,
   output logic [PAYLOAD_BITS-1:0] rd_payload_ff,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [PAYLOAD_BITS-1:0] wr_payload
);

   logic [KEY_BITS-1:0]     key_mem     [DEPTH];
   logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]     <= wr_key;
         payload_mem[wr_addr] <= wr_payload;
      end
      if (rd_en) begin
         rd_key_ff     <= key_mem[rd_addr];
         rd_payload_ff <= payload_mem[rd_addr];
      end
   end

endmodule

// File: rtl/sorted_priority_queue.sv
// Enqueue writes straight into an empty store; otherwise it scans down from the top entry,
// moving up a slot each stored entry whose key is greater than the new key.
// Dequeue emits the head, then shifts the rest down; range scans all; failures skip scans.
// The pace is one stored entry per cycle through the single store read port and comparator.
// Results appear in the cycle after they are found; the receiver cannot stall them.
// Reset clears the entry count and the sequencer; store contents stay undefined.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int KEY_BITS     = KEY_BITS_DEFAULT,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int KXW = KEY_BITS + 32;
   localparam int PXW = PAYLOAD_BITS + 32;

   typedef enum logic [2:0] {
      IDLE,
      ENQ_SCAN,
      ENQ_HEAD,
      DEQ_HEAD,
      DEQ_SHIFT,
      RNG_SCAN,
      RNG_END
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [KEY_BITS-1:0]     low_ff, low_in;
   logic [KEY_BITS-1:0]     high_ff, high_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [KEY_BITS-1:0]     pend_key_ff, pend_key_in;
   logic [PAYLOAD_BITS-1:0] pend_payload_ff, pend_payload_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    mem_rd_en;
   logic [AW-1:0]           mem_rd_addr;
   logic [KEY_BITS-1:0]     mem_rd_key;
   logic [PAYLOAD_BITS-1:0] mem_rd_payload;
   logic                    mem_wr_en;
   logic [AW-1:0]           mem_wr_addr;
   logic [KEY_BITS-1:0]     mem_wr_key;
   logic [PAYLOAD_BITS-1:0] mem_wr_payload;

   logic [KXW-1:0]          req_key_x, req_low_x, req_high_x, emit_key_x;
   logic [PXW-1:0]          req_payload_x, emit_payload_x;
   logic [KEY_BITS-1:0]     req_key, req_low, req_high, emit_key;
   logic [PAYLOAD_BITS-1:0] req_payload, emit_payload;
   logic [CW-1:0]           count_m1;
   logic                    at_last, in_range, emit_ok, emit_last;

   // Request fields are fitted to the stored widths; results are cut back to 32 bits.
   assign req_key_x      = {{KEY_BITS{1'b0}}, req_data.item_key};
   assign req_low_x      = {{KEY_BITS{1'b0}}, req_data.range_low};
   assign req_high_x     = {{KEY_BITS{1'b0}}, req_data.range_high};
   assign req_payload_x  = {{PAYLOAD_BITS{1'b0}}, req_data.item_payload};
   assign req_key        = req_key_x[KEY_BITS-1:0];
   assign req_low        = req_low_x[KEY_BITS-1:0];
   assign req_high       = req_high_x[KEY_BITS-1:0];
   assign req_payload    = req_payload_x[PAYLOAD_BITS-1:0];
   assign emit_key_x     = {{32{1'b0}}, emit_key};
   assign emit_payload_x = {{32{1'b0}}, emit_payload};

   assign count_m1 = count_ff - CW'(1);
   assign at_last  = (CW'(idx_ff) == count_m1);
   assign in_range = (mem_rd_key >= low_ff) && (mem_rd_key <= high_ff);

   spq_store #(
      .DEPTH        (DEPTH),
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_store (
      .clock         (clock),
      .rd_en         (mem_rd_en),
      .rd_addr       (mem_rd_addr),
      .rd_key_ff     (mem_rd_key),
      .rd_payload_ff (mem_rd_payload),
      .wr_en         (mem_wr_en),
      .wr_addr       (mem_wr_addr),
      .wr_key        (mem_wr_key),
      .wr_payload    (mem_wr_payload)
   );

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      key_in          = key_ff;
      payload_in      = payload_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      pend_valid_in   = pend_valid_ff;
      pend_key_in     = pend_key_ff;
      pend_payload_in = pend_payload_ff;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = idx_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = idx_ff;
      mem_wr_key      = key_ff;
      mem_wr_payload  = payload_ff;
      rsp_valid_in    = 1'b0;
      emit_ok         = 1'b0;
      emit_last       = 1'b1;
      emit_key        = '0;
      emit_payload    = '0;

      case (state_ff)
         IDLE: begin
            if (start) begin
               key_in        = req_key;
               payload_in    = req_payload;
               low_in        = req_low;
               high_in       = req_high;
               pend_valid_in = 1'b0;
               idx_in        = '0;
               mem_rd_addr   = '0;
               case (req_data.action)
                  ACT_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == '0) begin
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = '0;
                        mem_wr_key     = req_key;
                        mem_wr_payload = req_payload;
                        count_in       = count_ff + CW'(1);
                        rsp_valid_in   = 1'b1;
                        emit_ok        = 1'b1;
                        emit_key       = req_key;
                        emit_payload   = req_payload;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = count_m1[AW-1:0];
                        idx_in      = count_m1[AW-1:0];
                        state_in    = ENQ_SCAN;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_rd_en = 1'b1;
                        state_in  = DEQ_HEAD;
                     end
                  end
                  ACT_RANGE: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        mem_rd_en = 1'b1;
                        state_in  = RNG_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ENQ_SCAN: begin
            // Entries with a greater key move up one slot; the new entry lands above
            // the first entry whose key is not greater, keeping arrival order.
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff + AW'(1);
            if (mem_rd_key > key_ff) begin
               mem_wr_key     = mem_rd_key;
               mem_wr_payload = mem_rd_payload;
               if (idx_ff == '0) begin
                  state_in = ENQ_HEAD;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = idx_ff - AW'(1);
                  idx_in      = idx_ff - AW'(1);
               end
            end else begin
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               emit_ok      = 1'b1;
               emit_key     = key_ff;
               emit_payload = payload_ff;
               state_in     = IDLE;
            end
         end
         ENQ_HEAD: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = '0;
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            emit_ok      = 1'b1;
            emit_key     = key_ff;
            emit_payload = payload_ff;
            state_in     = IDLE;
         end
         DEQ_HEAD: begin
            rsp_valid_in = 1'b1;
            emit_ok      = 1'b1;
            emit_key     = mem_rd_key;
            emit_payload = mem_rd_payload;
            if (count_ff == CW'(1)) begin
               count_in = '0;
               state_in = IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(1);
               idx_in      = AW'(1);
               state_in    = DEQ_SHIFT;
            end
         end
         DEQ_SHIFT: begin
            mem_wr_en      = 1'b1;
            mem_wr_addr    = idx_ff - AW'(1);
            mem_wr_key     = mem_rd_key;
            mem_wr_payload = mem_rd_payload;
            if (at_last) begin
               count_in = count_m1;
               state_in = IDLE;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + AW'(1);
               idx_in      = idx_ff + AW'(1);
            end
         end
         RNG_SCAN: begin
            // A match is held back until the next one shows it was not the final one.
            if (in_range) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  emit_ok      = 1'b1;
                  emit_last    = 1'b0;
                  emit_key     = pend_key_ff;
                  emit_payload = pend_payload_ff;
               end
               pend_valid_in   = 1'b1;
               pend_key_in     = mem_rd_key;
               pend_payload_in = mem_rd_payload;
            end
            if (at_last) begin
               state_in = RNG_END;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff + AW'(1);
               idx_in      = idx_ff + AW'(1);
            end
         end
         RNG_END: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               emit_ok      = 1'b1;
               emit_key     = pend_key_ff;
               emit_payload = pend_payload_ff;
            end
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      rsp_data_in.ok          = emit_ok;
      rsp_data_in.out_key     = emit_key_x[31:0];
      rsp_data_in.out_payload = emit_payload_x[31:0];
      rsp_data_in.last        = emit_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      idx_ff          <= idx_in;
      key_ff          <= key_in;
      payload_ff      <= payload_in;
      low_ff          <= low_in;
      high_ff         <= high_in;
      pend_key_ff     <= pend_key_in;
      pend_payload_ff <= pend_payload_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
